FILE: hw/rtl/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, also checked during reset
`define ASSERT_CLK_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and codes of the LSB embed / extract core.
// ----------------------------------------------------------------------------
package lsbse_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_FILE_SMALL = 3'd1,
        STATUS_IMG_SMALL  = 3'd2,
        STATUS_BAD_LEN    = 3'd3,
        STATUS_CORRUPT    = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_FILE_SIZE = 2'd1;
    localparam logic [1:0] CFG_MSG_LEN   = 2'd2;

    // Mode register values
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam int LEN_W = 17;

endpackage

FILE: hw/rtl/lsb_stego_embed_extract_core.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_core
// LSB message embed / extract over the byte stream of an image file.
// ----------------------------------------------------------------------------
// The core takes one file byte per cycle while the result side accepts, and
// registers its result: the item sits in an input register while a single pass
// of compare and shift logic on the 32-bit position counter works out the
// result, which lands in an output register. In embed mode every item yields
// one result; in extract mode one result comes per eight message-carrying
// items, plus one error result where a check fails. The position counter
// wraps to zero after file_size items. Write the configuration only while no
// item is in flight.
module lsb_stego_embed_extract_core
    import lsbse_pkg::*;
#(
    parameter int HEADER_BYTES      = 54,
    parameter int MAX_MESSAGE_BYTES = 100000
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] file_byte, [15:8] message_byte
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);

    localparam logic [31:0] HDR    = 32'(HEADER_BYTES);
    localparam logic [32:0] HDR_32 = 33'(HEADER_BYTES) + 33'd32;
    localparam logic [35:0] HDR36  = 36'(HEADER_BYTES);
    localparam logic [31:0] MAXL   = 32'(MAX_MESSAGE_BYTES);

    // configuration
    logic             mode_reg;
    logic [31:0]      fs_reg;
    logic [LEN_W-1:0] len_reg;

    // file state
    logic [31:0] pos_reg,  pos_next;
    logic [31:0] ls_reg,   ls_next;
    logic [7:0]  bs_reg,   bs_next;
    logic        el_reg,   el_next;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  fb_reg;
    logic [7:0]  mb_reg;

    // output stage
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    status_t     out_status_reg;
    logic        out_last_reg;

    // datapath
    logic        out_free;
    logic        work;
    logic [31:0] off;
    logic [31:0] fs_m1;
    logic [31:0] room;
    logic [31:0] len32;
    logic [20:0] need_enc;
    logic [35:0] dec_end;
    logic        pos_ge_hdr;
    logic        pos_zero;
    logic        in_len_field;
    logic        enc_in_msg;
    logic        dec_in_msg;
    logic        fs_lt_hdr;
    logic        fs_lt_hdr32;
    status_t     enc_status;
    status_t     dec_err;
    logic [7:0]  src;
    logic        res_valid;
    logic [7:0]  res_byte;
    status_t     res_status;
    logic        res_last;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign work          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // position and size decode
    assign off          = pos_reg - HDR;
    assign fs_m1        = fs_reg - 32'd1;
    assign room         = fs_reg - HDR;
    assign len32        = {{(32 - LEN_W){1'b0}}, len_reg};
    assign need_enc     = {1'b0, len_reg, 3'b000} + 21'd32;
    assign dec_end      = {1'b0, ls_reg, 3'b000} + 36'd32;
    assign pos_ge_hdr   = pos_reg >= HDR;
    assign pos_zero     = pos_reg == 32'd0;
    assign in_len_field = pos_ge_hdr && (off[31:5] == 27'd0);
    assign enc_in_msg   = pos_ge_hdr && (off[31:5] != 27'd0)
                          && ({4'b0, off} < {15'b0, need_enc});
    assign dec_in_msg   = pos_ge_hdr && (off[31:5] != 27'd0) && (ls_reg <= MAXL)
                          && ({4'b0, off} < dec_end);
    assign fs_lt_hdr    = fs_reg < HDR;
    assign fs_lt_hdr32  = {1'b0, fs_reg} < HDR_32;

    // embed status from the registers
    always_comb
    begin
        if (fs_lt_hdr)
            enc_status = STATUS_FILE_SMALL;
        else if (room < {11'b0, need_enc})
            enc_status = STATUS_IMG_SMALL;
        else
            enc_status = STATUS_OK;
    end

    // per-item result and next state
    always_comb
    begin
        ls_next    = ls_reg;
        bs_next    = bs_reg;
        el_next    = el_reg;
        src        = bs_reg;
        dec_err    = STATUS_OK;
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_status = STATUS_OK;
        res_last   = 1'b0;

        if (mode_reg == MODE_EMBED)
        begin
            res_valid  = 1'b1;
            res_byte   = fb_reg;
            res_status = enc_status;
            if (enc_status == STATUS_OK)
            begin
                if (in_len_field)
                begin
                    // length, top bit first
                    res_byte = {fb_reg[7:1], len32[~off[4:0]]};
                end
                else if (enc_in_msg)
                begin
                    // fresh message byte on its top bit, else the shifter
                    src      = (off[2:0] == 3'd0) ? mb_reg : bs_reg;
                    res_byte = {fb_reg[7:1], src[7]};
                    bs_next  = {src[6:0], 1'b0};
                end
            end
            res_last = pos_reg == fs_m1;
        end
        else
        begin
            // file start: clear latch, check size
            if (pos_zero)
            begin
                el_next = 1'b0;
                if (fs_lt_hdr)
                    dec_err = STATUS_FILE_SMALL;
                else if (fs_lt_hdr32)
                    dec_err = STATUS_CORRUPT;
            end
            if (!el_next && dec_err == STATUS_OK)
            begin
                if (in_len_field)
                begin
                    // gather length
                    if (off[4:0] == 5'd0)
                        ls_next = {31'b0, fb_reg[0]};
                    else
                        ls_next = {ls_reg[30:0], fb_reg[0]};
                    if (off[4:0] == 5'd31)
                    begin
                        bs_next = 8'd0;
                        if (ls_next == 32'd0 || ls_next > MAXL)
                            dec_err = STATUS_BAD_LEN;
                        else if ({4'b0, fs_reg} <
                                 HDR36 + {1'b0, ls_next, 3'b000} + 36'd32)
                            dec_err = STATUS_CORRUPT;
                    end
                end
                else if (dec_in_msg)
                begin
                    // gather message bits, emit on every eighth
                    bs_next = {bs_reg[6:0], fb_reg[0]};
                    if (off[2:0] == 3'd7)
                    begin
                        res_valid  = 1'b1;
                        res_byte   = bs_next;
                        res_status = STATUS_OK;
                        res_last   = {4'b0, off} == (dec_end - 36'd1);
                    end
                end
            end
            if (dec_err != STATUS_OK)
            begin
                el_next    = 1'b1;
                res_valid  = 1'b1;
                res_byte   = 8'd0;
                res_status = dec_err;
                res_last   = 1'b1;
            end
        end

        // position wraps at file end
        pos_next = pos_reg + 32'd1;
        if (pos_next == fs_reg)
            pos_next = 32'd0;
        if (pos_next == 32'd0)
            el_next = 1'b0;
    end

    // output valid
    always_comb
    begin
        if (work)
            out_valid_next = res_valid;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_EMBED;
            fs_reg        <= 32'd0;
            len_reg       <= '0;
            pos_reg       <= 32'd0;
            ls_reg        <= 32'd0;
            bs_reg        <= 8'd0;
            el_reg        <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:      mode_reg <= cfg_data[0];
                    CFG_FILE_SIZE: fs_reg   <= cfg_data;
                    CFG_MSG_LEN:   len_reg  <= cfg_data[LEN_W-1:0];
                    default:       ;
                endcase
            end
            if (work)
            begin
                pos_reg <= pos_next;
                ls_reg  <= ls_next;
                bs_reg  <= bs_next;
                el_reg  <= el_next;
            end
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            fb_reg <= s_axis_tdata[7:0];
            mb_reg <= s_axis_tdata[15:8];
        end
        if (work && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

endmodule

FILE: hw/rtl/lsbse_checker.sv
// ----------------------------------------------------------------------------
// lsbse_checker
// Port-level checks of the LSB embed / extract core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsbse_checker
    import lsbse_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // result valid cleared by reset
    `ASSERT_CLK_RST(a_no_out_in_reset, clk,
        !rst_n |=> !m_axis_tvalid,
        "result after reset edge")

    // stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled result changed")

    // extract errors carry zero data and close the run
    `ASSERT_CLK(a_err_result, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == STATUS_BAD_LEN || m_axis_tuser == STATUS_CORRUPT)
            |-> m_axis_tdata == 8'd0 && m_axis_tlast,
        "bad error result")

    // a fresh result follows an earlier accepted item
    `ASSERT_CLK(a_out_cause, clk, rst_n,
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2),
        "result without item")

endmodule

bind lsb_stego_embed_extract_core lsbse_checker u_lsbse_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LSB embed / extract core. Plain tasks send the
// bytes of whole image files, laid out so that the length field and the
// message reach the deep states. A scoreboard class predicts every result
// item from its own copy of the registers and the position state, and checks
// each item the core gives against the oldest prediction. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lsbse_pkg::*;

    localparam int HDR          = 54;
    localparam int MAX_MSG      = 100000;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET  = 650;

    typedef struct {
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } out_item_t;

    // Predicts the result items of the core and checks the ones it gives
    class embed_extract_checker;
        bit         mode;
        bit [31:0]  file_size;
        bit [16:0]  msg_len;
        bit [31:0]  pos;
        bit [31:0]  len_sr;
        bit [7:0]   bit_sr;
        bit         err_latch;
        out_item_t  pending_out[$];
        int         errors;
        int         items;

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MODE:      mode = data[0];
                CFG_FILE_SIZE: file_size = data;
                CFG_MSG_LEN:   msg_len = data[16:0];
                default:       ;
            endcase
        endfunction

        function int pending();
            return pending_out.size();
        endfunction

        // One accepted file byte: update the state, queue what it yields
        function void take_file_byte(bit [7:0] fb, bit [7:0] mb);
            longint unsigned p, fs, ln, msg_end;
            int unsigned     sh;
            status_t         st;
            bit [7:0]        ob, src;
            bit [31:0]       nxt;
            p  = 64'(pos);
            fs = 64'(file_size);
            st = STATUS_OK;
            items++;
            if (mode == MODE_EMBED) begin
                ln = 64'(msg_len);
                ob = fb;
                if (fs < HDR)
                    st = STATUS_FILE_SMALL;
                else if (fs - HDR < (4 + ln) * 8)
                    st = STATUS_IMG_SMALL;
                if (st == STATUS_OK) begin
                    if (p >= HDR && p < HDR + 32) begin
                        // length field, msb first
                        sh = 32'(31 - (p - HDR));
                        ob = {fb[7:1], ln[sh]};
                    end
                    else if (p >= HDR + 32 && p < HDR + 32 + 8 * ln) begin
                        // new message byte on every eighth carrier
                        src    = (((p - HDR - 32) & 7) == 0) ? mb : bit_sr;
                        ob     = {fb[7:1], src[7]};
                        bit_sr = {src[6:0], 1'b0};
                    end
                end
                pending_out.push_back('{out_byte: ob, status: st,
                                        last: (pos == file_size - 32'd1)});
            end
            else begin
                if (p == 0) begin
                    err_latch = 1'b0;
                    if (fs < HDR)
                        st = STATUS_FILE_SMALL;
                    else if (fs < HDR + 32)
                        st = STATUS_CORRUPT;
                end
                if (!err_latch && st == STATUS_OK) begin
                    msg_end = HDR + 32 + 8 * longint'(len_sr);
                    if (p >= HDR && p < HDR + 32) begin
                        len_sr = (p == HDR) ? {31'b0, fb[0]} : {len_sr[30:0], fb[0]};
                        if (p == HDR + 31) begin
                            bit_sr  = '0;
                            msg_end = HDR + 32 + 8 * longint'(len_sr);
                            if (len_sr == 0 || len_sr > MAX_MSG)
                                st = STATUS_BAD_LEN;
                            else if (fs < msg_end)
                                st = STATUS_CORRUPT;
                        end
                    end
                    else if (p >= HDR + 32 && len_sr <= MAX_MSG && p < msg_end) begin
                        bit_sr = {bit_sr[6:0], fb[0]};
                        if (((p - HDR - 32) & 7) == 7)
                            pending_out.push_back('{out_byte: bit_sr, status: STATUS_OK,
                                                    last: (p == msg_end - 1)});
                    end
                end
                if (st != STATUS_OK) begin
                    err_latch = 1'b1;
                    pending_out.push_back('{out_byte: 8'h00, status: st, last: 1'b1});
                end
            end
            // position wraps after file_size bytes
            nxt = pos + 32'd1;
            if (nxt == file_size)
                nxt = '0;
            if (nxt == 0)
                err_latch = 1'b0;
            pos = nxt;
        endfunction

        function void report(string field, int exp_val, int act_val);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
            errors++;
        endfunction

        function void check_out_byte(logic [7:0] data, logic [2:0] st, logic lst);
            out_item_t e;
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data 0x%0h status %0d",
                         $time, data, st);
                errors++;
                return;
            end
            e = pending_out.pop_front();
            if (data !== e.out_byte)
                report("out_byte", e.out_byte, data);
            if (st !== e.status)
                report("status", e.status, st);
            if (lst !== e.last)
                report("last", e.last, lst);
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [7:0] file_byte, [15:8] message_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] out_byte
    logic [2:0]  m_axis_tuser;         // [2:0] status
    logic        m_axis_tlast;

    embed_extract_checker chk = new();
    bit steady;        // phase with no idling on either side
    int stall_left  = 0;
    int idle_cycles = 0;

    lsb_stego_embed_extract_core #(
        .HEADER_BYTES      (HDR),
        .MAX_MESSAGE_BYTES (MAX_MSG)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_out_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Register write; caller lowers cfg_valid after its last write
    task automatic cfg_push(input logic [1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        chk.write_reg(idx, data);
    endtask

    task automatic configure(input bit m, input bit [31:0] fs, input bit [16:0] ln);
        cfg_push(CFG_MODE, {31'b0, m});
        cfg_push(CFG_FILE_SIZE, fs);
        cfg_push(CFG_MSG_LEN, {15'b0, ln});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input bit [7:0] fb, input bit [7:0] mb);
        int gap;
        s_axis_tdata  <= {mb, fb};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chk.take_file_byte(fb, mb);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Idle until every prediction is met and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random file bytes; optionally a length field planted in the LSBs
    task automatic send_file(input int n, input bit use_len, input bit [31:0] len_field,
                             input int pause_at);
        bit [7:0] fb;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (chk.pending() != 0)
                    @(posedge clk);
            end
            fb = 8'($urandom);
            if (use_len && i >= HDR && i < HDR + 32)
                fb[0] = len_field[31 - (i - HDR)];
            send_item(fb, 8'($urandom));
        end
    endtask

    // Close an unfinished file by shrinking file_size to one past the position
    task automatic end_file();
        if (chk.pos != 0)
        begin
            settle();
            cfg_push(CFG_FILE_SIZE, chk.pos + 32'd1);
            cfg_valid <= 1'b0;
            send_item(8'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_phase(input int ph);
        bit        m, big, use_len;
        bit [31:0] fs, len_field;
        bit [16:0] ln;
        int        sel, n, msg_bytes, pause_at;
        steady    = ($urandom_range(0, 3) == 0);
        m         = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
        big       = (ph < 2) || ($urandom_range(0, 9) == 0);
        sel       = $urandom_range(0, 9);
        pause_at  = (ph == 2 || $urandom_range(0, 9) == 0) ? $urandom_range(HDR, HDR + 40) : -1;
        ln        = 17'($urandom_range(0, MAX_MSG));
        use_len   = 1'b1;
        msg_bytes = $urandom_range(1, 6);
        len_field = msg_bytes;
        if (m == MODE_EMBED)
        begin
            if (big)
            begin
                ln = 17'($urandom_range(0, 6));
                fs = 32'hFFFF_FFFF;
                n  = HDR + 32 + 8 * ln + $urandom_range(0, 8);
            end
            else if (sel == 0)
            begin
                fs = $urandom_range(0, HDR - 1);
                n  = (fs == 0) ? 20 : fs;
            end
            else if (sel == 1)
            begin
                // too little room for length and message
                if ($urandom_range(0, 1))
                begin
                    ln = 17'($urandom_range(1, 6));
                    fs = $urandom_range(HDR, HDR + 32 + 8 * ln - 1);
                end
                else
                begin
                    ln = 17'(MAX_MSG);
                    fs = $urandom_range(HDR, HDR + 60);
                end
                n = fs;
            end
            else
            begin
                ln = (sel == 2) ? 17'd0 : 17'($urandom_range(1, 6));
                fs = HDR + 32 + 8 * ln + $urandom_range(0, 12);
                n  = fs;
            end
        end
        else
        begin
            if (big)
            begin
                fs = 32'hFFFF_FFFF;
                n  = HDR + 32 + 8 * msg_bytes + $urandom_range(0, 8);
            end
            else if (sel == 0)
                fs = $urandom_range(1, HDR - 1);
            else if (sel == 1)
                fs = $urandom_range(HDR, HDR + 31);
            else if (sel == 2)
            begin
                // bad length: zero, above the maximum, or top bit set
                case ($urandom_range(0, 2))
                    0:       len_field = '0;
                    1:       len_field = $urandom_range(MAX_MSG + 1, 32'hFFFF_FFFF);
                    default: len_field = {1'b1, 31'($urandom)};
                endcase
                fs = HDR + 32 + $urandom_range(0, 40);
            end
            else if (sel == 3)
                fs = $urandom_range(HDR + 32, HDR + 32 + 8 * msg_bytes - 1);
            else if (sel == 4)
            begin
                use_len = 1'b0;
                fs      = HDR + 32 + $urandom_range(0, 60);
            end
            else
                fs = HDR + 32 + 8 * msg_bytes + $urandom_range(0, 10);
            if (!big)
                n = fs;
        end
        settle();
        configure(m, fs, ln);
        send_file(n, use_len, len_field, pause_at);
        end_file();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // embed, file_size zero: all bytes pass, file too small
        configure(MODE_EMBED, 32'd0, 17'd0);
        send_item(8'h00, 8'h00);
        send_item(8'hFF, 8'hFF);
        send_item(8'($urandom), 8'($urandom));
        end_file();

        // embed, tiny file with the largest message length
        settle();
        configure(MODE_EMBED, 32'd10, 17'(MAX_MSG));
        send_file(10, 1'b0, '0, -1);

        // extract, file_size zero: error on the first byte only
        settle();
        configure(MODE_EXTRACT, 32'd0, 17'd0);
        send_file(3, 1'b0, '0, -1);
        end_file();

        // extract, file shorter than the header
        settle();
        configure(MODE_EXTRACT, 32'd5, 17'd1);
        send_file(5, 1'b0, '0, -1);

        for (int ph = 0; chk.items < ITEM_TARGET; ph++)
            run_phase(ph);

        settle();
        if (chk.errors == 0 && chk.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
